>>> hw/rtl/ars_pkg.sv
`timescale 1ns / 1ps

package ars_pkg;

   localparam int SineEntries = 65;
   localparam logic [6:0] SINE_QUADRANT = 7'd64;
   localparam logic [7:0] COS_OFFSET = 8'h40;
   localparam int FracShift = 14;

   // First quadrant of the Q14 sine, 0 to 90 degrees inclusive.
   localparam logic [14:0] QUARTER_SINE [SineEntries] = '{
      15'h0000, 15'h0192, 15'h0323, 15'h04B5, 15'h0645, 15'h07D5, 15'h0964, 15'h0AF1,
      15'h0C7C, 15'h0E05, 15'h0F8C, 15'h1111, 15'h1294, 15'h1413, 15'h158F, 15'h1708,
      15'h187D, 15'h19EF, 15'h1B5D, 15'h1CC6, 15'h1E2B, 15'h1F8B, 15'h20E7, 15'h223D,
      15'h238E, 15'h24DA, 15'h261F, 15'h275F, 15'h2899, 15'h29CD, 15'h2AFA, 15'h2C21,
      15'h2D41, 15'h2E5A, 15'h2F6B, 15'h3076, 15'h3179, 15'h3274, 15'h3367, 15'h3453,
      15'h3536, 15'h3612, 15'h36E5, 15'h37AF, 15'h3871, 15'h392A, 15'h39DA, 15'h3A82,
      15'h3B20, 15'h3BB6, 15'h3C42, 15'h3CC5, 15'h3D3E, 15'h3DAE, 15'h3E14, 15'h3E71,
      15'h3EC5, 15'h3F0E, 15'h3F4E, 15'h3F84, 15'h3FB1, 15'h3FD3, 15'h3FEC, 15'h3FFB,
      15'h4000
   };

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [15:0] disp_x;
      logic signed [15:0] disp_y;
      logic signed [15:0] scale_x;
      logic signed [15:0] scale_y;
      logic [15:0]        angle;
      logic               last;
   } req_type;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [15:0] disp_x;
      logic signed [15:0] disp_y;
      logic signed [15:0] scale_x;
      logic signed [15:0] scale_y;
      logic signed [15:0] sin_q14;
      logic signed [15:0] cos_q14;
      logic               last;
   } trig_type;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [15:0] disp_x;
      logic signed [15:0] disp_y;
      logic signed [15:0] pa;
      logic signed [15:0] ms;
      logic signed [15:0] pc;
      logic signed [15:0] pd;
      logic               last;
   } term_type;

   typedef struct packed {
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic signed [31:0] prod_ax;
      logic signed [31:0] prod_sy;
      logic signed [31:0] prod_cx;
      logic signed [31:0] prod_dy;
      logic signed [15:0] pa;
      logic signed [15:0] ms;
      logic signed [15:0] pc;
      logic signed [15:0] pd;
      logic               last;
   } prod_type;

   typedef struct packed {
      logic signed [15:0] pa;
      logic signed [15:0] pb;
      logic signed [15:0] pc;
      logic signed [15:0] pd;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic               last;
   } rsp_type;

   // Q14 sine of a 256-step angle, folded from the quarter table.
   function automatic logic signed [15:0] ars_sine(input logic [7:0] idx);
      logic [6:0]         half;
      logic signed [15:0] mag;
      half = idx[6:0];
      if (half > SINE_QUADRANT) begin
         half = 7'(8'd128 - {1'b0, half});
      end
      mag = $signed({1'b0, QUARTER_SINE[half]});
      return idx[7] ? 16'(-mag) : mag;
   endfunction

endpackage

>>> hw/rtl/ars_trig_stage.sv
`timescale 1ns / 1ps

module ars_trig_stage (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  ars_pkg::req_type  in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output ars_pkg::trig_type out_data
);
   import ars_pkg::*;

   logic     valid_ff;
   trig_type data_ff;
   logic [7:0] theta;

   assign theta    = in_data.angle[15:8];
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff.center_x <= in_data.center_x;
         data_ff.center_y <= in_data.center_y;
         data_ff.disp_x   <= in_data.disp_x;
         data_ff.disp_y   <= in_data.disp_y;
         data_ff.scale_x  <= in_data.scale_x;
         data_ff.scale_y  <= in_data.scale_y;
         data_ff.sin_q14  <= ars_sine(theta);
         data_ff.cos_q14  <= ars_sine(theta + COS_OFFSET);
         data_ff.last     <= in_data.last;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> hw/rtl/ars_term_stage.sv
`timescale 1ns / 1ps

module ars_term_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  ars_pkg::trig_type  in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output ars_pkg::term_type  out_data
);
   import ars_pkg::*;

   logic     valid_ff;
   term_type data_ff;
   logic signed [31:0] prod_a, prod_s, prod_c, prod_d;

   // Products stay within 30 bits, so floor shift plus 16-bit wrap is a slice.
   assign prod_a = 32'(in_data.scale_x) * 32'(in_data.cos_q14);
   assign prod_s = 32'(in_data.scale_x) * 32'(in_data.sin_q14);
   assign prod_c = 32'(in_data.scale_y) * 32'(in_data.sin_q14);
   assign prod_d = 32'(in_data.scale_y) * 32'(in_data.cos_q14);

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff.center_x <= in_data.center_x;
         data_ff.center_y <= in_data.center_y;
         data_ff.disp_x   <= in_data.disp_x;
         data_ff.disp_y   <= in_data.disp_y;
         data_ff.pa       <= prod_a[FracShift +: 16];
         data_ff.ms       <= prod_s[FracShift +: 16];
         data_ff.pc       <= prod_c[FracShift +: 16];
         data_ff.pd       <= prod_d[FracShift +: 16];
         data_ff.last     <= in_data.last;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> hw/rtl/ars_start_stage.sv
`timescale 1ns / 1ps

module ars_start_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  ars_pkg::term_type  in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output ars_pkg::rsp_type   out_data
);
   import ars_pkg::*;

   logic     prod_valid_ff;
   prod_type prod_ff;
   logic     prod_ready;
   logic     rsp_valid_ff;
   rsp_type  rsp_ff;

   // Displacement products, wrapping in 32 bits.
   assign prod_ready = !rsp_valid_ff || out_ready;
   assign in_ready   = !prod_valid_ff || prod_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (in_ready) begin
         prod_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         prod_ff.center_x <= in_data.center_x;
         prod_ff.center_y <= in_data.center_y;
         prod_ff.prod_ax  <= 32'(in_data.pa) * 32'(in_data.disp_x);
         prod_ff.prod_sy  <= 32'(in_data.ms) * 32'(in_data.disp_y);
         prod_ff.prod_cx  <= 32'(in_data.pc) * 32'(in_data.disp_x);
         prod_ff.prod_dy  <= 32'(in_data.pd) * 32'(in_data.disp_y);
         prod_ff.pa       <= in_data.pa;
         prod_ff.ms       <= in_data.ms;
         prod_ff.pc       <= in_data.pc;
         prod_ff.pd       <= in_data.pd;
         prod_ff.last     <= in_data.last;
      end
   end

   // Final sums and the negated shear term.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (prod_ready) begin
         rsp_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_ready && prod_valid_ff) begin
         rsp_ff.pa      <= prod_ff.pa;
         rsp_ff.pb      <= 16'(16'sd0 - prod_ff.ms);
         rsp_ff.pc      <= prod_ff.pc;
         rsp_ff.pd      <= prod_ff.pd;
         rsp_ff.start_x <= prod_ff.center_x - prod_ff.prod_ax + prod_ff.prod_sy;
         rsp_ff.start_y <= prod_ff.center_y - prod_ff.prod_cx - prod_ff.prod_dy;
         rsp_ff.last    <= prod_ff.last;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

endmodule

>>> hw/rtl/affine_rotscale_params_unit.sv
`timescale 1ns / 1ps

// Rotation and scaling parameter unit. Every request word carries one record
// (texture center, screen displacement, 8.8 x and y scale and a 16-bit angle of
// which only the top byte counts) and yields exactly one response word with the
// four matrix terms pa, pb, pc and pd, wrapped to 16 bits, and the 32-bit start
// point, in the same order as the requests. The unit is a four-stage pipeline:
// sine and cosine table lookup, scale multiplies, displacement multiplies, and
// the final sums into the output register. It accepts one word every clock
// while the response side is not stalled by back pressure; the throughput is set
// by these registered stages, each holding either the table lookup, one level
// of multipliers or the final adders, and each moving whenever the next is free.
// Each stage holds its word while the next one is full, so a stall on the
// response side backs up through the stages without losing or repeating a word,
// and a free stage keeps taking words while a finished response waits. The
// object variant simply uses pa through pd and ignores the start point. There
// is no programmable state; the synchronous reset only empties the pipeline.

module affine_rotscale_params_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // center_x[31:0], center_y[63:32], disp_x[79:64], disp_y[95:80],
   // scale_x[111:96], scale_y[127:112], angle[143:128]
   input  logic [143:0] req_tdata,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // pa[15:0], pb[31:16], pc[47:32], pd[63:48], start_x[95:64], start_y[127:96]
   output logic [127:0] rsp_tdata,
   output logic         rsp_tlast
);
   import ars_pkg::*;

   req_type  req_word;
   trig_type trig_word;
   term_type term_word;
   rsp_type  rsp_word;
   logic     trig_valid, trig_ready;
   logic     term_valid, term_ready;

   // Unpack the request word into its fields.
   assign req_word.center_x = $signed(req_tdata[31:0]);
   assign req_word.center_y = $signed(req_tdata[63:32]);
   assign req_word.disp_x   = $signed(req_tdata[79:64]);
   assign req_word.disp_y   = $signed(req_tdata[95:80]);
   assign req_word.scale_x  = $signed(req_tdata[111:96]);
   assign req_word.scale_y  = $signed(req_tdata[127:112]);
   assign req_word.angle    = req_tdata[143:128];
   assign req_word.last     = req_tlast;

   // Stage one: sine and cosine from the quarter-wave table.
   ars_trig_stage u_trig (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_word),
      .out_valid (trig_valid),
      .out_ready (trig_ready),
      .out_data  (trig_word)
   );

   // Stage two: scale times trig, floor shift by 14, wrap to 16 bits.
   ars_term_stage u_term (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (trig_valid),
      .in_ready  (trig_ready),
      .in_data   (trig_word),
      .out_valid (term_valid),
      .out_ready (term_ready),
      .out_data  (term_word)
   );

   // Stages three and four: displacement products, then the start point sums.
   ars_start_stage u_start (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (term_valid),
      .in_ready  (term_ready),
      .in_data   (term_word),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_word)
   );

   // Pack the response word.
   assign rsp_tdata = {rsp_word.start_y, rsp_word.start_x,
                       rsp_word.pd, rsp_word.pc, rsp_word.pb, rsp_word.pa};
   assign rsp_tlast = rsp_word.last;

endmodule

>>> hw/rtl/ars_checker.sv
`timescale 1ns / 1ps

module ars_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [143:0] req_tdata,
   input logic         req_tlast,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [127:0] rsp_tdata,
   input logic         rsp_tlast
);

   // Reset empties the pipeline.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // A waiting response word holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response word changed while stalled");

   // With the output register empty every stage can move, so a request is taken.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with an empty output register");

   // With no back pressure an accepted word moves through every stage to the response.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && rsp_tready) ##1 rsp_tready ##1 rsp_tready
      ##1 rsp_tready |=> rsp_tvalid)
      else $error("response missing four cycles after a request");

   // An accepted request word carries no unknown bits.
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !$isunknown(req_tlast) && !$isunknown(req_tdata))
      else $error("unknown request word accepted");

endmodule

bind affine_rotscale_params_unit ars_checker u_ars_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
